// ===== sv/byte_ring_buffer_with_peek_macros.svh =====
// Assertion macros shared by the ring buffer RTL.
// No dependencies; included inside module bodies.
`ifndef BYTE_RING_BUFFER_WITH_PEEK_MACROS_SVH
`define BYTE_RING_BUFFER_WITH_PEEK_MACROS_SVH

// same-cycle implication
`define BRBP_ASSERT_IMP(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("brbp assertion failed");

// next-cycle implication
`define BRBP_ASSERT_NXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("brbp assertion failed");

`endif

// ===== sv/brbp_pkg.sv =====
// Shared types and codes for the byte ring buffer.
// No dependencies.
package brbp_pkg;

    typedef logic [1:0] t_req_kind;

    localparam t_req_kind REQ_WRITE   = 2'd0;
    localparam t_req_kind REQ_READ    = 2'd1;
    localparam t_req_kind REQ_PEEK    = 2'd2;
    localparam t_req_kind REQ_DISCARD = 2'd3;

    typedef struct packed {
        logic accept;
        logic load_out;
    } t_cmd;

endpackage

// ===== sv/brbp_intf.sv =====
// Valid/ready channel interfaces for requests and responses.
// Depends on brbp_pkg.
interface brbp_req_if;
    import brbp_pkg::*;
    logic       valid;
    logic       ready;
    t_req_kind  req_type;
    logic [7:0] data_byte;
    logic [7:0] amount;

    modport source (output valid, req_type, data_byte, amount, input ready);
    modport sink   (input valid, req_type, data_byte, amount, output ready);
endinterface

interface brbp_rsp_if;
    logic       valid;
    logic       ready;
    logic       ok;
    logic [7:0] read_byte;
    logic [7:0] moved_count;
    logic [7:0] fill_level;
    logic [7:0] free_space;

    modport source (output valid, ok, read_byte, moved_count, fill_level, free_space,
                    input ready);
    modport sink   (input valid, ok, read_byte, moved_count, fill_level, free_space,
                    output ready);
endinterface

// ===== sv/brbp_ctrl.sv =====
// Request sequencer: accept, memory read cycle, response handoff.
// Depends on brbp_pkg and byte_ring_buffer_with_peek_macros.svh.
module brbp_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    output logic            o_out_valid,
    input  logic            i_out_ready,
    output brbp_pkg::t_cmd  o_cmd
);
    import brbp_pkg::*;
    `include "byte_ring_buffer_with_peek_macros.svh"

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_EXEC = 1'b1;

    logic r_state, n_state;
    logic r_out_valid, n_out_valid;
    t_cmd cmd;

    always_comb begin
        cmd.accept   = (r_state == ST_IDLE) && i_in_valid;
        cmd.load_out = (r_state == ST_EXEC) && (!r_out_valid || i_out_ready);
        n_state      = r_state;
        case (r_state)
            ST_IDLE: begin
                if (cmd.accept) n_state = ST_EXEC;
            end
            ST_EXEC: begin
                if (cmd.load_out) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
        if (cmd.load_out) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_cmd       = cmd;

    `BRBP_ASSERT_NXT(a_accept_to_exec, i_clk, i_rst_n, cmd.accept, r_state == ST_EXEC)
    `BRBP_ASSERT_IMP(a_no_overwrite, i_clk, i_rst_n, cmd.load_out, !r_out_valid || i_out_ready)
    `BRBP_ASSERT_NXT(a_exec_waits, i_clk, i_rst_n,
        r_state == ST_EXEC && r_out_valid && !i_out_ready, r_state == ST_EXEC)
endmodule

// ===== sv/brbp_dpath.sv =====
// Ring storage, positions, fill count and response registers.
// Depends on brbp_pkg and byte_ring_buffer_with_peek_macros.svh.
module brbp_dpath #(
    parameter int DEPTH = 256
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  brbp_pkg::t_cmd       i_cmd,
    input  brbp_pkg::t_req_kind  i_req_type,
    input  logic [7:0]           i_data_byte,
    input  logic [7:0]           i_amount,
    output logic                 o_ok,
    output logic [7:0]           o_read_byte,
    output logic [7:0]           o_moved_count,
    output logic [7:0]           o_fill_level,
    output logic [7:0]           o_free_space
);
    import brbp_pkg::*;
    `include "byte_ring_buffer_with_peek_macros.svh"

    localparam int PW = $clog2(DEPTH);
    localparam int CW = (PW > 8) ? PW : 8;
    localparam logic [PW-1:0] LAST   = PW'(DEPTH - 1);
    localparam logic [PW:0]   DEPTH_W = (PW+1)'(DEPTH);
    localparam logic [CW-1:0] MAXC   = CW'(DEPTH - 1);

    logic [7:0]    mem [DEPTH];

    logic [PW-1:0] r_rd_pos, r_wr_pos, r_fill;
    logic [PW-1:0] n_rd_pos, n_wr_pos, n_fill;
    logic [7:0]    r_rdata;
    logic          r_p_ok, r_p_byte_en;
    logic [7:0]    r_p_moved, r_p_fill, r_p_free;
    logic          r_ok;
    logic [7:0]    r_read_byte, r_moved, r_fill_lvl, r_free;

    logic [CW-1:0] fill_c, amt_c, del_c, nfill_c, free_c;
    logic [PW-1:0] off, step, rd_wrap, addr;
    logic [PW:0]   rd_sum;
    logic          full, empty, peek_hit, we, ok, byte_en;
    logic [7:0]    moved;

    always_comb begin
        fill_c   = CW'(r_fill);
        amt_c    = CW'(i_amount);
        full     = (r_fill == LAST);
        empty    = (r_fill == '0);
        peek_hit = amt_c < fill_c;
        del_c    = peek_hit ? amt_c : fill_c;
        off      = del_c[PW-1:0];
        step     = (i_req_type == REQ_READ) ? PW'(1) : off;
        rd_sum   = {1'b0, r_rd_pos} + {1'b0, step};
        rd_wrap  = (rd_sum >= DEPTH_W) ? PW'(rd_sum - DEPTH_W) : rd_sum[PW-1:0];
        addr     = (i_req_type == REQ_READ) ? r_rd_pos : rd_wrap;

        we       = 1'b0;
        ok       = 1'b0;
        byte_en  = 1'b0;
        moved    = 8'd0;
        n_rd_pos = r_rd_pos;
        n_wr_pos = r_wr_pos;
        n_fill   = r_fill;
        case (i_req_type)
            REQ_WRITE: begin
                if (!full) begin
                    we       = 1'b1;
                    ok       = 1'b1;
                    moved    = 8'd1;
                    n_wr_pos = (r_wr_pos == LAST) ? '0 : r_wr_pos + PW'(1);
                    n_fill   = r_fill + PW'(1);
                end
            end
            REQ_READ: begin
                if (!empty) begin
                    ok       = 1'b1;
                    byte_en  = 1'b1;
                    moved    = 8'd1;
                    n_rd_pos = rd_wrap;
                    n_fill   = r_fill - PW'(1);
                end
            end
            REQ_PEEK: begin
                if (peek_hit) begin
                    ok      = 1'b1;
                    byte_en = 1'b1;
                    moved   = 8'd1;
                end
            end
            REQ_DISCARD: begin
                ok       = 1'b1;
                moved    = del_c[7:0];
                n_rd_pos = rd_wrap;
                n_fill   = r_fill - off;
            end
            default: ;
        endcase
        nfill_c = CW'(n_fill);
        free_c  = MAXC - nfill_c;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            if (we) mem[r_wr_pos] <= i_data_byte;
            r_rdata <= mem[addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_pos <= '0;
            r_wr_pos <= '0;
            r_fill   <= '0;
        end else if (i_cmd.accept) begin
            r_rd_pos <= n_rd_pos;
            r_wr_pos <= n_wr_pos;
            r_fill   <= n_fill;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_p_ok      <= ok;
            r_p_byte_en <= byte_en;
            r_p_moved   <= moved;
            r_p_fill    <= (nfill_c > CW'(255)) ? 8'hFF : nfill_c[7:0];
            r_p_free    <= (free_c > CW'(255)) ? 8'hFF : free_c[7:0];
        end
        if (i_cmd.load_out) begin
            r_ok        <= r_p_ok;
            r_read_byte <= r_p_byte_en ? r_rdata : 8'd0;
            r_moved     <= r_p_moved;
            r_fill_lvl  <= r_p_fill;
            r_free      <= r_p_free;
        end
    end

    assign o_ok          = r_ok;
    assign o_read_byte   = r_read_byte;
    assign o_moved_count = r_moved;
    assign o_fill_level  = r_fill_lvl;
    assign o_free_space  = r_free;

    logic [PW-1:0] ptr_diff;
    assign ptr_diff = (r_wr_pos >= r_rd_pos) ? r_wr_pos - r_rd_pos
                                             : PW'(DEPTH_W - {1'b0, r_rd_pos - r_wr_pos});

    `BRBP_ASSERT_IMP(a_fill_bound, i_clk, i_rst_n, 1'b1, r_fill <= LAST)
    `BRBP_ASSERT_IMP(a_fill_matches_ptrs, i_clk, i_rst_n, 1'b1, r_fill == ptr_diff)
    `BRBP_ASSERT_NXT(a_full_write_drops, i_clk, i_rst_n,
        i_cmd.accept && i_req_type == REQ_WRITE && full, $stable(r_wr_pos))
endmodule

// ===== sv/byte_ring_buffer_with_peek.sv =====
// Byte ring buffer with peek and discard: top level.
// Depends on brbp_pkg, brbp_intf, brbp_ctrl and brbp_dpath.
//
//   port    dir   modport  carries
//   i_req   in    sink     req_type, data_byte, amount
//   o_rsp   out   source   ok, read_byte, moved_count, fill_level, free_space
//
// The accept edge updates positions and starts the registered storage read;
// the response register is loaded once the previous response has been taken.
// A new request is taken while the previous response still waits on o_rsp.
// Synchronous active-low reset empties the buffer; storage is not cleared.
// A stalled response holds the block in its execute state.
module byte_ring_buffer_with_peek #(
    parameter int DEPTH = 256
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    brbp_req_if.sink    i_req,
    brbp_rsp_if.source  o_rsp
);
    import brbp_pkg::*;

    t_cmd cmd;

    brbp_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_req.valid),
        .o_in_ready  (i_req.ready),
        .o_out_valid (o_rsp.valid),
        .i_out_ready (o_rsp.ready),
        .o_cmd       (cmd)
    );

    brbp_dpath #(
        .DEPTH (DEPTH)
    ) u_dpath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .i_req_type    (i_req.req_type),
        .i_data_byte   (i_req.data_byte),
        .i_amount      (i_req.amount),
        .o_ok          (o_rsp.ok),
        .o_read_byte   (o_rsp.read_byte),
        .o_moved_count (o_rsp.moved_count),
        .o_fill_level  (o_rsp.fill_level),
        .o_free_space  (o_rsp.free_space)
    );
endmodule

// ===== tb/byte_ring_buffer_with_peek_tb.sv =====
// Self-checking testbench for byte_ring_buffer_with_peek: directed and phased random requests
// with random idle cycles on both channels; responses are checked against an in-bench model.
// Depends on brbp_pkg, brbp_intf and the byte_ring_buffer_with_peek RTL.
module byte_ring_buffer_with_peek_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import brbp_pkg::*;

    localparam int DEPTH       = 256;
    localparam int STALL_LIMIT = 2000;
    localparam int ITEM_GOAL   = 1200;

    typedef struct packed {
        t_req_kind  kind;
        logic [7:0] data;
        logic [7:0] amt;
    } t_req_item;

    typedef struct packed {
        logic       ok;
        logic [7:0] rd_byte;
        logic [7:0] moved;
        logic [7:0] fill;
        logic [7:0] space;
    } t_ring_rsp;

    logic i_clk = 1'b0;
    logic i_rst_n;

    brbp_req_if req_bus ();
    brbp_rsp_if rsp_bus ();

    byte_ring_buffer_with_peek #(
        .DEPTH(DEPTH)
    ) u_dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (req_bus),
        .o_rsp  (rsp_bus)
    );

    always begin
        #10ns i_clk = 1'b1;
        #10ns i_clk = 1'b0;
    end

    t_req_item req_pending_q[$];
    t_ring_rsp rsp_expected_q[$];

    logic [7:0] ring_cells [DEPTH];
    int         ring_rd;
    int         ring_wr;

    int gen_fill;
    int n_gen;
    int req_accepted;
    int rsp_seen;
    int err_cnt;
    int stall_cycles;

    function automatic int ring_level();
        return (ring_wr >= ring_rd) ? ring_wr - ring_rd : DEPTH - (ring_rd - ring_wr);
    endfunction

    function automatic logic [7:0] clip8(int v);
        return (v > 255) ? 8'd255 : v[7:0];
    endfunction

    // advances the bench copy of the buffer by one request
    function automatic t_ring_rsp ring_predict(t_req_kind kind, logic [7:0] data,
                                               logic [7:0] amt);
        t_ring_rsp r;
        int        lvl;
        int        drop;
        r   = '0;
        lvl = ring_level();
        case (kind)
            REQ_WRITE: begin
                if (lvl < DEPTH - 1) begin
                    ring_cells[ring_wr] = data;
                    ring_wr = (ring_wr + 1) % DEPTH;
                    r.ok    = 1'b1;
                    r.moved = 8'd1;
                end
            end
            REQ_READ: begin
                if (lvl > 0) begin
                    r.rd_byte = ring_cells[ring_rd];
                    ring_rd   = (ring_rd + 1) % DEPTH;
                    r.ok      = 1'b1;
                    r.moved   = 8'd1;
                end
            end
            REQ_PEEK: begin
                if (int'(amt) < lvl) begin
                    r.rd_byte = ring_cells[(ring_rd + int'(amt)) % DEPTH];
                    r.ok      = 1'b1;
                    r.moved   = 8'd1;
                end
            end
            default: begin
                drop    = (int'(amt) < lvl) ? int'(amt) : lvl;
                ring_rd = (ring_rd + drop) % DEPTH;
                r.ok    = 1'b1;
                r.moved = clip8(drop);
            end
        endcase
        lvl     = ring_level();
        r.fill  = clip8(lvl);
        r.space = clip8(DEPTH - 1 - lvl);
        return r;
    endfunction

    // generation side keeps its own fill count to steer the phases
    task automatic queue_req(t_req_kind kind, logic [7:0] data, logic [7:0] amt);
        int drop;
        case (kind)
            REQ_WRITE:   if (gen_fill < DEPTH - 1) gen_fill++;
            REQ_READ:    if (gen_fill > 0) gen_fill--;
            REQ_DISCARD: begin
                drop     = (int'(amt) < gen_fill) ? int'(amt) : gen_fill;
                gen_fill = gen_fill - drop;
            end
            default: ;
        endcase
        req_pending_q.push_back('{kind: kind, data: data, amt: amt});
        n_gen++;
    endtask

    function automatic logic [7:0] peek_offset();
        int r;
        r = $urandom_range(0, 99);
        if (gen_fill == 0 || r >= 85) return 8'($urandom_range(0, 255));
        if (r < 60) return 8'($urandom_range(0, gen_fill - 1));
        if (r < 75) return 8'(gen_fill - 1);
        return clip8(gen_fill);
    endfunction

    task automatic flag_error(string msg);
        if (err_cnt < 10) $display("ERROR @%0t: %s", $realtime, msg);
        err_cnt++;
    endtask

    // request driver
    always @(posedge i_clk) begin : drv
        logic      gap;
        t_req_item nxt;
        if (!i_rst_n) begin
            req_bus.valid <= 1'b0;
        end else begin
            gap = !(req_accepted >= 400 && req_accepted < 700) && ($urandom_range(0, 99) < 6);
            if (req_bus.valid && req_bus.ready) begin
                rsp_expected_q.push_back(ring_predict(req_bus.req_type, req_bus.data_byte,
                                                      req_bus.amount));
                req_accepted <= req_accepted + 1;
            end
            if (!req_bus.valid || req_bus.ready) begin
                if (req_pending_q.size() != 0 && !gap) begin
                    nxt = req_pending_q.pop_front();
                    req_bus.valid     <= 1'b1;
                    req_bus.req_type  <= nxt.kind;
                    req_bus.data_byte <= nxt.data;
                    req_bus.amount    <= nxt.amt;
                end else begin
                    req_bus.valid <= 1'b0;
                end
            end
        end
    end

    // response monitor and checker
    always @(posedge i_clk) begin : mon
        t_ring_rsp got;
        t_ring_rsp want;
        if (!i_rst_n) begin
            rsp_bus.ready <= 1'b0;
        end else begin
            rsp_bus.ready <= (rsp_seen >= 400 && rsp_seen < 700) ||
                             ($urandom_range(0, 99) >= 6);
            if (rsp_bus.valid && rsp_bus.ready) begin
                rsp_seen <= rsp_seen + 1;
                got = '{ok: rsp_bus.ok, rd_byte: rsp_bus.read_byte,
                        moved: rsp_bus.moved_count, fill: rsp_bus.fill_level,
                        space: rsp_bus.free_space};
                if (rsp_expected_q.size() == 0) begin
                    flag_error($sformatf({"response with none expected: ok=%0b byte=%02h ",
                                          "moved=%0d fill=%0d free=%0d"},
                                         got.ok, got.rd_byte, got.moved, got.fill,
                                         got.space));
                end else begin
                    want = rsp_expected_q.pop_front();
                    if (got.ok !== want.ok || got.rd_byte !== want.rd_byte ||
                        got.moved !== want.moved || got.fill !== want.fill ||
                        got.space !== want.space) begin
                        flag_error($sformatf({"response %0d: exp ok=%0b byte=%02h moved=%0d ",
                                              "fill=%0d free=%0d, got ok=%0b byte=%02h ",
                                              "moved=%0d fill=%0d free=%0d"},
                                             rsp_seen, want.ok, want.rd_byte, want.moved,
                                             want.fill, want.space, got.ok, got.rd_byte,
                                             got.moved, got.fill, got.space));
                    end
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready))
                stall_cycles <= 0;
            else
                stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("Mismatches found");
                $finish;
            end
        end
    end

    initial begin
        int r;
        req_bus.valid     = 1'b0;
        req_bus.req_type  = REQ_WRITE;
        req_bus.data_byte = 8'h00;
        req_bus.amount    = 8'h00;
        rsp_bus.ready     = 1'b0;
        i_rst_n           = 1'b0;
        ring_rd      = 0;
        ring_wr      = 0;
        gen_fill     = 0;
        n_gen        = 0;
        req_accepted = 0;
        rsp_seen     = 0;
        err_cnt      = 0;
        stall_cycles = 0;
        foreach (ring_cells[i]) ring_cells[i] = 8'h00;

        // empty buffer corner cases
        queue_req(REQ_READ,    8'hFF, 8'hFF);
        queue_req(REQ_PEEK,    8'h00, 8'h00);
        queue_req(REQ_DISCARD, 8'h00, 8'h00);
        queue_req(REQ_DISCARD, 8'hFF, 8'hFF);
        // data extremes, peeks inside and past the fill level
        queue_req(REQ_WRITE,   8'h00, 8'hFF);
        queue_req(REQ_WRITE,   8'hFF, 8'h00);
        queue_req(REQ_WRITE,   8'hA5, 8'h5A);
        queue_req(REQ_WRITE,   8'h5A, 8'hA5);
        queue_req(REQ_PEEK,    8'hFF, 8'd0);
        queue_req(REQ_PEEK,    8'h00, 8'd3);
        queue_req(REQ_PEEK,    8'h00, 8'd4);
        queue_req(REQ_PEEK,    8'h00, 8'd255);
        queue_req(REQ_READ,    8'h00, 8'h00);
        queue_req(REQ_DISCARD, 8'hFF, 8'd0);
        queue_req(REQ_DISCARD, 8'h00, 8'd1);
        queue_req(REQ_DISCARD, 8'h00, 8'd255);
        queue_req(REQ_WRITE,   8'h81, 8'h00);
        queue_req(REQ_READ,    8'h00, 8'h00);
        queue_req(REQ_READ,    8'h00, 8'h00);
        queue_req(REQ_PEEK,    8'h00, 8'd255);

        // phased random traffic; always starts by filling to full
        r = 0;
        while (n_gen < ITEM_GOAL) begin
            case (r)
                0, 1: begin
                    while (gen_fill < DEPTH - 1 && n_gen < ITEM_GOAL) begin
                        r = $urandom_range(0, 99);
                        if (r < 88)      queue_req(REQ_WRITE, 8'($urandom), 8'($urandom));
                        else if (r < 94) queue_req(REQ_PEEK, 8'($urandom), peek_offset());
                        else             queue_req(REQ_READ, 8'($urandom), 8'($urandom));
                    end
                    repeat ($urandom_range(1, 4))
                        queue_req(REQ_WRITE, 8'($urandom), 8'($urandom));
                end
                2, 3, 4: begin
                    repeat ($urandom_range(20, 80)) begin
                        r = $urandom_range(0, 99);
                        if (r < 45)      queue_req(REQ_READ, 8'($urandom), 8'($urandom));
                        else if (r < 70) queue_req(REQ_PEEK, 8'($urandom), peek_offset());
                        else if (r < 95) queue_req(REQ_DISCARD, 8'($urandom),
                                                   8'($urandom_range(0, 6)));
                        else             queue_req(REQ_DISCARD, 8'($urandom), 8'($urandom));
                    end
                end
                5, 6, 7: begin
                    repeat (40) begin
                        r = $urandom_range(0, 99);
                        if (r < 40)      queue_req(REQ_WRITE, 8'($urandom), 8'($urandom));
                        else if (r < 60) queue_req(REQ_READ, 8'($urandom), 8'($urandom));
                        else if (r < 85) queue_req(REQ_PEEK, 8'($urandom), peek_offset());
                        else             queue_req(REQ_DISCARD, 8'($urandom),
                                                   8'($urandom_range(0, 12)));
                    end
                end
                default: begin
                    queue_req(REQ_DISCARD, 8'($urandom), 8'd255);
                    repeat ($urandom_range(2, 6)) begin
                        r = $urandom_range(0, 2);
                        queue_req(r == 0 ? REQ_READ : (r == 1 ? REQ_PEEK : REQ_DISCARD),
                                  8'($urandom), 8'($urandom));
                    end
                end
            endcase
            r = $urandom_range(0, 9);
        end

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (req_accepted != n_gen) @(posedge i_clk);
        while (rsp_expected_q.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);

        if (err_cnt == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
